// File: hw/rtl/mct_pkg.sv
package mct_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int KEY_W      = 32;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 16;
  localparam int TOTAL_W    = 20;
  localparam int DISTINCT_W = 5;
  localparam int EXT_W      = 64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD        = 2'd0,
    FUNC_REMOVE_ONE = 2'd1,
    FUNC_REMOVE_ALL = 2'd2,
    FUNC_QUERY      = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_SATURATED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_NEW,
    OP_INC,
    OP_DEC,
    OP_CLEAR
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Ripple signals passed from cell to cell during lookup.
  typedef struct packed {
    logic hit;   // some cell up to here matches the key
    logic free;  // some cell up to here is free
  } chain_t;

  // Update command broadcast to all cells.
  typedef struct packed {
    cell_op_t           op;
    logic [KEY_W-1:0]   key;
  } cell_cmd_t;

endpackage

// File: hw/rtl/mct_channels.sv
interface mct_req_if;
  logic                            valid;
  logic                            ready;
  logic [mct_pkg::FUNC_W-1:0]      func;
  logic signed [mct_pkg::KEY_W-1:0] element;

  modport source (output valid, output func, output element, input ready);
  modport sink   (input valid, input func, input element, output ready);
endinterface

interface mct_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [mct_pkg::STATUS_W-1:0]      status;
  logic [mct_pkg::OCC_W-1:0]         occurrences;
  logic [mct_pkg::TOTAL_W-1:0]       total_size;
  logic [mct_pkg::DISTINCT_W-1:0]    distinct_count;
  logic                              is_empty;

  modport source (output valid, output status, output occurrences, output total_size,
                  output distinct_count, output is_empty, input ready);
  modport sink   (input valid, input status, input occurrences, input total_size,
                  input distinct_count, input is_empty, output ready);
endinterface

// File: hw/rtl/mct_cell.sv
module mct_cell #(
  parameter int COUNT_WIDTH = mct_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       lookup_en,
  input  logic [mct_pkg::KEY_W-1:0]  key_in,
  input  mct_pkg::chain_t            chain_in,
  input  logic [COUNT_WIDTH-1:0]     cnt_in,
  output mct_pkg::chain_t            chain_out,
  output logic [COUNT_WIDTH-1:0]     cnt_out,
  input  logic                       apply,
  input  mct_pkg::cell_cmd_t         cmd
);

  logic [mct_pkg::KEY_W-1:0] key;
  logic [COUNT_WIDTH-1:0]    count;
  logic                      valid;
  logic                      hit;
  logic                      claim;
  logic                      match;

  assign match           = valid && (key == key_in);
  assign chain_out.hit   = chain_in.hit | match;
  assign chain_out.free  = chain_in.free | !valid;
  assign cnt_out         = cnt_in | (match ? count : '0);

  // Lookup result held for the update cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit   <= 1'b0;
      claim <= 1'b0;
    end else if (lookup_en) begin
      hit   <= match;
      claim <= !valid && !chain_in.free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (apply) begin
      case (cmd.op)
        mct_pkg::OP_NEW:   if (claim) valid <= 1'b1;
        mct_pkg::OP_DEC:   if (hit && count <= COUNT_WIDTH'(1)) valid <= 1'b0;
        mct_pkg::OP_CLEAR: if (hit) valid <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      case (cmd.op)
        mct_pkg::OP_NEW: begin
          if (claim) begin
            key   <= cmd.key;
            count <= COUNT_WIDTH'(1);
          end
        end
        mct_pkg::OP_INC:   if (hit) count <= count + COUNT_WIDTH'(1);
        mct_pkg::OP_DEC: begin
          if (hit) count <= (count <= COUNT_WIDTH'(1)) ? '0 : count - COUNT_WIDTH'(1);
        end
        mct_pkg::OP_CLEAR: if (hit) count <= '0;
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/multiset_count_table_unit.sv
// The key is compared against all cells in the accepting cycle and the lookup result is held;
//   the UPDATE state applies it once the output register can take the response.
// A new request is taken only in IDLE, after the last one is updated; the lookup ripple across
//   the cell row and the update of the matched or claimed cell come one after the other.
// A finished response waits in an output register while the next request is looked up.
// Reset (rst, synchronous, active high) clears all valid marks, the totals, the
//   state machine and the output valid flag; keys and counts are not cleared.
module multiset_count_table_unit #(
  parameter int CAPACITY    = mct_pkg::CAPACITY_DEF,
  parameter int COUNT_WIDTH = mct_pkg::COUNT_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  mct_req_if.sink  req,
  mct_rsp_if.source rsp
);

  // Totals: at most CAPACITY * (2^COUNT_WIDTH - 1) occurrences.
  localparam int TOT_W = COUNT_WIDTH + $clog2(CAPACITY);
  localparam int UNQ_W = $clog2(CAPACITY + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  mct_pkg::state_t state, state_next;

  // Request held for the update cycle.
  mct_pkg::func_t              func;
  logic [mct_pkg::KEY_W-1:0]   req_key;
  logic                        any_hit;
  logic                        any_free;
  logic [COUNT_WIDTH-1:0]      hit_cnt;

  logic [TOT_W-1:0] total, total_next;
  logic [UNQ_W-1:0] unique_cnt, unique_next;

  // Output register.
  logic                             out_valid;
  mct_pkg::status_t                 out_status;
  logic [mct_pkg::OCC_W-1:0]        out_occ;
  logic [mct_pkg::TOTAL_W-1:0]      out_total;
  logic [mct_pkg::DISTINCT_W-1:0]   out_distinct;
  logic                             out_empty;

  logic                   accept;
  logic                   apply;
  mct_pkg::cell_cmd_t     cmd;
  mct_pkg::status_t       status_next;
  logic [COUNT_WIDTH-1:0] occ_next;

  mct_pkg::chain_t        chain [CAPACITY+1];
  logic [COUNT_WIDTH-1:0] cnt_chain [CAPACITY+1];

  logic [mct_pkg::EXT_W-1:0] occ_ext, total_ext, unique_ext;

  // ---------------------------------------------------------------------------
  // Control: IDLE takes a transaction while the cells compare its key;
  // UPDATE applies the operation once the output register can take the result.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      mct_pkg::ST_IDLE:   if (req.valid) state_next = mct_pkg::ST_UPDATE;
      mct_pkg::ST_UPDATE: if (!out_valid || rsp.ready) state_next = mct_pkg::ST_IDLE;
      default:            state_next = mct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    apply     = 1'b0;
    case (state)
      mct_pkg::ST_IDLE:   req.ready = 1'b1;
      mct_pkg::ST_UPDATE: apply = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) state <= mct_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // ---------------------------------------------------------------------------
  // Cell row. Hit, free and matched count ripple from cell 0 upward; the first
  // free cell claims itself for a new key.
  // ---------------------------------------------------------------------------
  assign chain[0]     = '{hit: 1'b0, free: 1'b0};
  assign cnt_chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mct_cell #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .lookup_en (accept),
      .key_in    (req.element),
      .chain_in  (chain[i]),
      .cnt_in    (cnt_chain[i]),
      .chain_out (chain[i+1]),
      .cnt_out   (cnt_chain[i+1]),
      .apply     (apply),
      .cmd       (cmd)
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func     <= mct_pkg::func_t'(req.func);
      req_key  <= req.element;
      any_hit  <= chain[CAPACITY].hit;
      any_free <= chain[CAPACITY].free;
      hit_cnt  <= cnt_chain[CAPACITY];
    end
  end

  // ---------------------------------------------------------------------------
  // Decision for the held request.
  // ---------------------------------------------------------------------------
  always_comb begin
    status_next = mct_pkg::STATUS_OK;
    occ_next    = '0;
    total_next  = total;
    unique_next = unique_cnt;
    cmd.op      = mct_pkg::OP_NONE;
    cmd.key     = req_key;
    case (func)
      mct_pkg::FUNC_ADD: begin
        if (any_hit) begin
          if (hit_cnt == COUNT_MAX) begin
            status_next = mct_pkg::STATUS_SATURATED;
            occ_next    = COUNT_MAX;
          end else begin
            cmd.op     = mct_pkg::OP_INC;
            occ_next   = hit_cnt + COUNT_WIDTH'(1);
            total_next = total + TOT_W'(1);
          end
        end else if (any_free) begin
          cmd.op      = mct_pkg::OP_NEW;
          occ_next    = COUNT_WIDTH'(1);
          total_next  = total + TOT_W'(1);
          unique_next = unique_cnt + UNQ_W'(1);
        end else begin
          status_next = mct_pkg::STATUS_FULL;
        end
      end
      mct_pkg::FUNC_REMOVE_ONE: begin
        if (any_hit) begin
          cmd.op     = mct_pkg::OP_DEC;
          total_next = total - TOT_W'(1);
          if (hit_cnt <= COUNT_WIDTH'(1)) begin
            unique_next = unique_cnt - UNQ_W'(1);
          end else begin
            occ_next = hit_cnt - COUNT_WIDTH'(1);
          end
        end else begin
          status_next = mct_pkg::STATUS_NOT_FOUND;
        end
      end
      mct_pkg::FUNC_REMOVE_ALL: begin
        if (any_hit) begin
          cmd.op      = mct_pkg::OP_CLEAR;
          occ_next    = hit_cnt;
          total_next  = total - TOT_W'(hit_cnt);
          unique_next = unique_cnt - UNQ_W'(1);
        end else begin
          status_next = mct_pkg::STATUS_NOT_FOUND;
        end
      end
      mct_pkg::FUNC_QUERY: begin
        if (any_hit) occ_next = hit_cnt;
        else         status_next = mct_pkg::STATUS_NOT_FOUND;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      unique_cnt <= '0;
    end else if (apply) begin
      total      <= total_next;
      unique_cnt <= unique_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register; fields are cut or zero-extended to the port widths.
  // ---------------------------------------------------------------------------
  assign occ_ext    = mct_pkg::EXT_W'(occ_next);
  assign total_ext  = mct_pkg::EXT_W'(total_next);
  assign unique_ext = mct_pkg::EXT_W'(unique_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      out_status   <= status_next;
      out_occ      <= occ_ext[mct_pkg::OCC_W-1:0];
      out_total    <= total_ext[mct_pkg::TOTAL_W-1:0];
      out_distinct <= unique_ext[mct_pkg::DISTINCT_W-1:0];
      out_empty    <= (total_next == '0);
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.occurrences    = out_occ;
  assign rsp.total_size     = out_total;
  assign rsp.distinct_count = out_distinct;
  assign rsp.is_empty       = out_empty;

`ifndef SYNTHESIS
  // Distinct keys never exceed the cell count.
  a_unique_bound: assert property (@(posedge clk) disable iff (rst)
    unique_cnt <= UNQ_W'(CAPACITY))
    else $error("distinct key count above capacity");

  // No keys held exactly when no occurrences are held.
  a_empty_match: assert property (@(posedge clk) disable iff (rst)
    (unique_cnt == '0) == (total == '0))
    else $error("distinct count and total disagree on emptiness");

  // A response appears only after an update cycle.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == mct_pkg::ST_UPDATE))
    else $error("response without update");

  // A waiting response agrees with the running total.
  a_rsp_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_empty == (total == '0)))
    else $error("empty flag out of step with total");
`endif

endmodule

// File: verif/count_table_monitor.sv
`timescale 1ns / 1ps
module count_table_monitor
  import mct_pkg::*;
(
  input  logic clk,
  input  logic rst,
  mct_req_if   req,
  mct_rsp_if   rsp,
  output int   mismatches,
  output int   responses_seen,
  output int   outstanding
);

  localparam int SLOTS = CAPACITY_DEF;
  localparam logic [OCC_W-1:0] COUNT_TOP = {COUNT_WIDTH_DEF{1'b1}};

  typedef struct packed {
    status_t                 status;
    logic [OCC_W-1:0]        occ;
    logic [TOTAL_W-1:0]      total;
    logic [DISTINCT_W-1:0]   distinct;
    logic                    empty;
  } reply_t;

  // shadow of the table contents
  logic [KEY_W-1:0]      slot_key   [SLOTS];
  logic [OCC_W-1:0]      slot_count [SLOTS];
  bit                    slot_used  [SLOTS];
  logic [TOTAL_W-1:0]    held_total;
  logic [DISTINCT_W-1:0] held_distinct;
  reply_t                expected_replies [$];

  // Applies one request to the shadow table and returns the reply it must produce.
  function automatic reply_t tally_update(func_t op, logic [KEY_W-1:0] key);
    int     hit;
    int     free_slot;
    reply_t r;
    hit       = -1;
    free_slot = -1;
    // scan downward so the lowest matching / free slot wins
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == key) hit = i;
      if (!slot_used[i]) free_slot = i;
    end
    r.status = STATUS_OK;
    r.occ    = '0;
    case (op)
      FUNC_ADD: begin
        if (hit >= 0) begin
          if (slot_count[hit] == COUNT_TOP) begin
            r.status = STATUS_SATURATED;
            r.occ    = COUNT_TOP;
          end else begin
            slot_count[hit] = slot_count[hit] + 1'b1;
            held_total      = held_total + 1'b1;
            r.occ           = slot_count[hit];
          end
        end else if (free_slot < 0) begin
          r.status = STATUS_FULL;
        end else begin
          slot_key[free_slot]   = key;
          slot_count[free_slot] = 1;
          slot_used[free_slot]  = 1'b1;
          held_total            = held_total + 1'b1;
          held_distinct         = held_distinct + 1'b1;
          r.occ                 = 1;
        end
      end
      FUNC_REMOVE_ONE: begin
        if (hit < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          if (slot_count[hit] <= 1) begin
            slot_used[hit]  = 1'b0;
            slot_count[hit] = '0;
            held_distinct   = held_distinct - 1'b1;
          end else begin
            slot_count[hit] = slot_count[hit] - 1'b1;
          end
          held_total = held_total - 1'b1;
          r.occ      = slot_count[hit];
        end
      end
      FUNC_REMOVE_ALL: begin
        if (hit < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          r.occ           = slot_count[hit];
          held_total      = held_total - slot_count[hit];
          slot_used[hit]  = 1'b0;
          slot_count[hit] = '0;
          held_distinct   = held_distinct - 1'b1;
        end
      end
      default: begin
        if (hit < 0) r.status = STATUS_NOT_FOUND;
        else r.occ = slot_count[hit];
      end
    endcase
    r.total    = held_total;
    r.distinct = held_distinct;
    r.empty    = (held_total == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      held_total     = '0;
      held_distinct  = '0;
      expected_replies.delete();
      mismatches     <= 0;
      responses_seen <= 0;
      outstanding    <= 0;
    end else begin
      if (req.valid && req.ready) begin
        expected_replies.push_back(tally_update(func_t'(req.func), req.element));
      end
      if (rsp.valid && rsp.ready) begin
        responses_seen <= responses_seen + 1;
        if (expected_replies.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: response with nothing pending: status %0d occ %0d total %0d",
                     $time, rsp.status, rsp.occurrences, rsp.total_size);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_replies.pop_front();
          if (rsp.status !== want.status || rsp.occurrences !== want.occ ||
              rsp.total_size !== want.total || rsp.distinct_count !== want.distinct ||
              rsp.is_empty !== want.empty) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch, expected status %0d occ %0d total %0d distinct %0d empty %0d",
                       $time, want.status, want.occ, want.total, want.distinct, want.empty);
              $display("%0t:           got      status %0d occ %0d total %0d distinct %0d empty %0d",
                       $time, rsp.status, rsp.occurrences, rsp.total_size,
                       rsp.distinct_count, rsp.is_empty);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= expected_replies.size();
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import mct_pkg::*;

  // No handshake for this many cycles means the block has hung.
  localparam int QUIET_LIMIT    = 2000;
  // Random requests per idling mix; three mixes give about 1100.
  localparam int RANDOM_PER_MIX = 370;
  // Small key pool so random traffic keeps hitting keys that are held,
  // fills the table and empties slots again.
  localparam int POOL_SIZE      = 24;
  // A run of adds on one key; the 16-bit count ceiling is far beyond this run.
  localparam int SAT_ADDS       = 40;
  localparam logic [KEY_W-1:0] SAT_KEY = 32'hA5A5_5A5A;

  logic clk;
  logic rst;

  int src_idle_pct;
  int sink_idle_pct;
  int sent_count;
  int quiet_cycles;
  int mismatches;
  int responses_seen;
  int outstanding;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  mct_req_if req_ch ();
  mct_rsp_if rsp_ch ();

  multiset_count_table_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Watches both channels, predicts every reply and compares it.
  count_table_monitor tally_mon (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatches     (mismatches),
    .responses_seen (responses_seen),
    .outstanding    (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Reply side backpressure: ready drops in sink_idle_pct of the cycles.
  always @(posedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Hang detector: restarts on every transaction on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("no transaction for %0d cycles", QUIET_LIMIT);
      $display("multiset_count_table_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request transaction. valid is only dropped when a gap is inserted, so
  // back-to-back requests keep valid high without a second assignment in the step.
  task automatic send_req(input func_t op, input logic [KEY_W-1:0] key);
    if ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.func    <= op;
    req_ch.element <= key;
    do @(posedge clk); while (!req_ch.ready);
    sent_count++;
  endtask

  // Random request: add-heavy so the table fills, mostly pool keys so
  // removes and queries hit, some fully random keys for miss and bit coverage.
  task automatic send_random();
    int               pick;
    func_t            op;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 45) op = FUNC_ADD;
    else if (pick < 65) op = FUNC_REMOVE_ONE;
    else if (pick < 75) op = FUNC_REMOVE_ALL;
    else op = FUNC_QUERY;
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else key = $urandom;
    send_req(op, key);
  endtask

  // One random phase under a given idling mix, with a fresh key pool.
  task automatic run_mix(input int src_pct, input int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'hFFFF_FFFF;
    key_pool[3] = 32'h0000_0000;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (RANDOM_PER_MIX) send_random();
  endtask

  initial begin
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.func    = FUNC_QUERY;
    req_ch.element = '0;
    rsp_ch.ready   = 1'b0;
    src_idle_pct   = 0;
    sink_idle_pct  = 0;
    sent_count     = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed: empty table, every lookup misses ---
    send_req(FUNC_QUERY, 32'd5);
    send_req(FUNC_REMOVE_ONE, 32'd5);
    send_req(FUNC_REMOVE_ALL, 32'd5);

    // key extremes, including the all-ones pattern (-1)
    send_req(FUNC_ADD, 32'h8000_0000);
    send_req(FUNC_ADD, 32'h7FFF_FFFF);
    send_req(FUNC_ADD, 32'hFFFF_FFFF);
    send_req(FUNC_ADD, 32'h0000_0000);
    send_req(FUNC_ADD, 32'hFFFF_FFFF);
    send_req(FUNC_QUERY, 32'hFFFF_FFFF);

    // removing the last occurrence frees the slot and drops the distinct count
    send_req(FUNC_REMOVE_ONE, 32'hFFFF_FFFF);
    send_req(FUNC_REMOVE_ONE, 32'hFFFF_FFFF);
    // re-add claims the lowest free slot; remove all reports the count dropped
    repeat (2) send_req(FUNC_ADD, 32'hFFFF_FFFF);
    send_req(FUNC_REMOVE_ALL, 32'hFFFF_FFFF);

    // fill the table: three keys held, add the rest
    for (int i = 0; i < CAPACITY_DEF - 3; i++) send_req(FUNC_ADD, 32'h0000_1000 + i);
    send_req(FUNC_ADD, 32'h0000_2000);   // new key into full table: refused
    send_req(FUNC_ADD, 32'h0000_0000);   // held key still counts up while full
    send_req(FUNC_QUERY, 32'h8000_0000);

    // drain back to empty
    send_req(FUNC_REMOVE_ALL, 32'h8000_0000);
    send_req(FUNC_REMOVE_ALL, 32'h7FFF_FFFF);
    send_req(FUNC_REMOVE_ALL, 32'h0000_0000);
    for (int i = 0; i < CAPACITY_DEF - 3; i++) send_req(FUNC_REMOVE_ALL, 32'h0000_1000 + i);

    // --- one key piled up with back-to-back adds, then taken down ---
    for (int i = 0; i < SAT_ADDS; i++) send_req(FUNC_ADD, SAT_KEY);
    send_req(FUNC_QUERY, SAT_KEY);
    send_req(FUNC_REMOVE_ONE, SAT_KEY);
    send_req(FUNC_REMOVE_ALL, SAT_KEY);

    // --- random traffic under three idling mixes ---
    run_mix(32, 79);
    run_mix(79, 32);
    run_mix(0, 0);

    req_ch.valid <= 1'b0;
    // every sent request owes exactly one reply
    while (responses_seen < sent_count) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests: empty/full/key-extreme cases, a %0d-add run on one key,",
             sent_count, SAT_ADDS);
    $display("and random traffic under three idling mixes; %0d replies checked",
             responses_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("multiset_count_table_unit regression: pass");
    end else begin
      $display("multiset_count_table_unit regression: fail");
    end
    $finish;
  end

endmodule
